>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/mrfp_pkg.sv
`timescale 1ns / 1ps
package mrfp_pkg;

   localparam logic [7:0] START_A     = 8'h01;
   localparam logic [7:0] START_B     = 8'h05;
   localparam logic [7:0] TAIL        = 8'h6B;
   localparam logic [7:0] CMD_POS     = 8'hFD;
   localparam logic [7:0] ACK_REACHED = 8'h9F;
   localparam logic [7:0] CMD_CURRENT = 8'h27;

   typedef enum logic [1:0] {
      FUNC_RX,
      FUNC_ARM_CAR,
      FUNC_ARM_CAR_CLEAR,
      FUNC_ARM_SLIDE_CLEAR
   } func_type;

   typedef enum logic [1:0] {
      CAR_MOVING,
      CAR_STOPPED,
      CAR_ERROR
   } car_status_type;

endpackage

>>> rtl/motor_reply_frame_parser_core.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------------
// request   | in        | req_valid/req_stall  | req_func, req_rx_byte
// response  | out       | rsp_valid/rsp_stall  | rsp_car_status, rsp_slide_stopped,
//           |           |                      | rsp_slide_current, rsp_frame_closed,
//           |           |                      | rsp_frame_error
//
// One request per cycle while req_stall is low; each request gives one response, passing
// through the input register at the accepting edge and then through the frame buffer update
// into the response register. Reset is synchronous; it clears the receive state, the
// frame buffer and the current value, and sets the car and slide status to stopped. A stalled
// response holds the response register; the input register then fills and req_stall rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motor_reply_frame_parser_core import mrfp_pkg::*; #(
   parameter int FRAME_MAX = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_car_status,
   output logic        rsp_slide_stopped,
   output logic [15:0] rsp_slide_current,
   output logic        rsp_frame_closed,
   output logic        rsp_frame_error
);

   localparam int CW = $clog2(FRAME_MAX);

   // input stage
   logic           s1_valid_ff;
   func_type       s1_func_ff;
   logic [7:0]     s1_byte_ff;

   // parser state
   logic           collecting_ff, collecting_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [7:0]     buf_ff [FRAME_MAX];
   logic [7:0]     buf_in [FRAME_MAX];
   car_status_type car_ff, car_in;
   logic           slide_ff, slide_in;
   logic [15:0]    current_ff, current_in;

   // response register
   logic           rsp_valid_ff;
   car_status_type rsp_car_ff;
   logic           rsp_slide_ff;
   logic [15:0]    rsp_current_ff;
   logic           rsp_closed_ff;
   logic           rsp_error_ff;

   logic           s1_advance;
   logic           req_accept;
   logic           fire;
   logic           closed_in;
   logic           error_in;
   logic           store;
   logic [CW:0]    count_inc;
   logic [7:0]     head [4];
   logic           match_car, match_slide, match_current;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign fire       = s1_valid_ff && s1_advance;

   assign count_inc = {1'b0, count_ff} + {{CW{1'b0}}, 1'b1};
   assign store     = collecting_ff || (s1_byte_ff == START_A) || (s1_byte_ff == START_B);

   // Frame head as it stands after this byte is stored.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         head[i] = (store && count_ff == CW'(i)) ? s1_byte_ff : buf_ff[i];
      end
   end

   assign match_car     = (head[0] == START_A) && (head[1] == CMD_POS) &&
                          (head[2] == ACK_REACHED);
   assign match_slide   = (head[0] == START_B) && (head[1] == CMD_POS) &&
                          (head[2] == ACK_REACHED) && !slide_ff;
   assign match_current = (head[0] == START_B) && (head[1] == CMD_CURRENT);

   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      buf_in        = buf_ff;
      car_in        = car_ff;
      slide_in      = slide_ff;
      current_in    = current_ff;
      closed_in     = 1'b0;
      error_in      = 1'b0;
      case (s1_func_ff)
         FUNC_ARM_CAR: begin
            car_in = CAR_MOVING;
         end
         FUNC_ARM_CAR_CLEAR: begin
            car_in = CAR_MOVING;
            for (int i = 0; i < 4; i++) buf_in[i] = '0;
         end
         FUNC_ARM_SLIDE_CLEAR: begin
            slide_in = 1'b0;
            for (int i = 0; i < 4; i++) buf_in[i] = '0;
         end
         default: begin
            if (store) begin
               buf_in[count_ff] = s1_byte_ff;
               count_in         = count_inc[CW-1:0];
               collecting_in    = 1'b1;
               if (count_inc >= (CW+1)'(FRAME_MAX) || s1_byte_ff == TAIL) begin
                  closed_in     = 1'b1;
                  collecting_in = 1'b0;
                  count_in      = '0;
                  if (s1_byte_ff == TAIL) begin
                     if (match_car) begin
                        car_in = CAR_STOPPED;
                        for (int i = 0; i < 4; i++) buf_in[i] = '0;
                     end else if (match_slide) begin
                        slide_in = 1'b1;
                        for (int i = 0; i < 4; i++) buf_in[i] = '0;
                     end else if (match_current) begin
                        current_in = {head[2], head[3]};
                     end else begin
                        for (int i = 0; i < FRAME_MAX; i++) buf_in[i] = '0;
                     end
                  end else begin
                     // buffer full without a tail
                     error_in = 1'b1;
                     car_in   = CAR_ERROR;
                     for (int i = 0; i < FRAME_MAX; i++) buf_in[i] = '0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_accept) begin
         s1_func_ff <= func_type'(req_func);
         s1_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         for (int i = 0; i < FRAME_MAX; i++) buf_ff[i] <= '0;
         car_ff        <= CAR_STOPPED;
         slide_ff      <= 1'b1;
         current_ff    <= '0;
      end else if (fire) begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         buf_ff        <= buf_in;
         car_ff        <= car_in;
         slide_ff      <= slide_in;
         current_ff    <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (fire) begin
         rsp_car_ff     <= car_in;
         rsp_slide_ff   <= slide_in;
         rsp_current_ff <= current_in;
         rsp_closed_ff  <= closed_in;
         rsp_error_ff   <= error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_car_status    = rsp_car_ff;
   assign rsp_slide_stopped = rsp_slide_ff;
   assign rsp_slide_current = rsp_current_ff;
   assign rsp_frame_closed  = rsp_closed_ff;
   assign rsp_frame_error   = rsp_error_ff;

   `ASSERT_IMPLIES(a_error_closes, clock, reset, rsp_valid_ff && rsp_error_ff, rsp_closed_ff && rsp_car_ff == CAR_ERROR)
   `ASSERT_IMPLIES(a_idle_count_zero, clock, reset, !collecting_ff, count_ff == '0)
   `ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, {1'b0, count_ff} < (CW+1)'(FRAME_MAX))
   `ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_byte_ff))

endmodule

>>> dv/tb_motor_reply_frame_parser_core.sv
`timescale 1ns / 1ps
module tb_motor_reply_frame_parser_core;
   import mrfp_pkg::*;

   localparam int FRAME_LEN     = 10;
   localparam int PHASE_ITEMS   = 433;
   localparam int HOLD_LEN      = 300;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [1:0]  car;
      logic        slide;
      logic [15:0] current;
      logic        closed;
      logic        error;
   } frame_reply;

   typedef struct packed {
      func_type   func;
      logic [7:0] rx;
      logic       pinned;
      frame_reply want;
   } stim_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_RX;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_car_status;
   logic        rsp_slide_stopped;
   logic [15:0] rsp_slide_current;
   logic        rsp_frame_closed;
   logic        rsp_frame_error;

   // expectation typed into the table rides along with the request
   logic        req_pinned = 1'b0;
   frame_reply  pinned_reply = '0;

   int send_idle_pct = 28;
   int recv_idle_pct = 69;
   int idle_phase = 1;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   // predictor state
   logic           rx_collecting = 1'b0;
   int             rx_count = 0;
   logic [7:0]     frame_bytes [FRAME_LEN];
   car_status_type car_state = CAR_STOPPED;
   logic           slide_state = 1'b1;
   logic [15:0]    current_value = 16'h0000;

   frame_reply reply_q [$];
   stim_row    burst [$];
   stim_row    directed_rows [29];

   motor_reply_frame_parser_core #(.FRAME_MAX(FRAME_LEN)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_car_status   (rsp_car_status),
      .rsp_slide_stopped(rsp_slide_stopped),
      .rsp_slide_current(rsp_slide_current),
      .rsp_frame_closed (rsp_frame_closed),
      .rsp_frame_error  (rsp_frame_error)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_frame(input int upto);
      for (int i = 0; i < upto; i++) frame_bytes[i] = 8'h00;
   endfunction

   function automatic frame_reply predict_reply(input func_type f, input logic [7:0] b);
      frame_reply r;
      logic store;
      r = '0;
      store = 1'b0;
      case (f)
         FUNC_ARM_CAR: car_state = CAR_MOVING;
         FUNC_ARM_CAR_CLEAR: begin
            car_state = CAR_MOVING;
            clear_frame(4);
         end
         FUNC_ARM_SLIDE_CLEAR: begin
            slide_state = 1'b0;
            clear_frame(4);
         end
         default: begin
            if (!rx_collecting) begin
               if (b == START_A || b == START_B) begin
                  rx_collecting = 1'b1;
                  store = 1'b1;
               end
            end else begin
               store = 1'b1;
            end
            if (store) begin
               frame_bytes[rx_count] = b;
               rx_count++;
               if (rx_count >= FRAME_LEN || b == TAIL) begin
                  r.closed = 1'b1;
                  rx_collecting = 1'b0;
                  rx_count = 0;
                  if (b == TAIL) begin
                     if (frame_bytes[0] == START_A && frame_bytes[1] == CMD_POS &&
                         frame_bytes[2] == ACK_REACHED) begin
                        car_state = CAR_STOPPED;
                        clear_frame(4);
                     end else if (frame_bytes[0] == START_B && frame_bytes[1] == CMD_POS &&
                                  frame_bytes[2] == ACK_REACHED && !slide_state) begin
                        slide_state = 1'b1;
                        clear_frame(4);
                     end else if (frame_bytes[0] == START_B &&
                                  frame_bytes[1] == CMD_CURRENT) begin
                        current_value = {frame_bytes[2], frame_bytes[3]};
                     end else begin
                        clear_frame(FRAME_LEN);
                     end
                  end else begin
                     r.error = 1'b1;
                     car_state = CAR_ERROR;
                     clear_frame(FRAME_LEN);
                  end
               end
            end
         end
      endcase
      r.car = car_state;
      r.slide = slide_state;
      r.current = current_value;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // entered and left just after a falling edge; valid stays up for a back-to-back request
   task automatic send_request(input stim_row row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= row.func;
      req_rx_byte <= row.rx;
      req_pinned <= row.pinned;
      pinned_reply <= row.want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic stim_row rx_row(input logic [7:0] b);
      return '{FUNC_RX, b, 1'b0, '0};
   endfunction

   function automatic logic [7:0] non_tail_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == TAIL) ? ~b : b;
   endfunction

   // fill the burst with one sequence; return how many requests count toward the total
   function automatic int build_burst();
      int kind;
      int shape;
      int extra;
      logic [7:0] start;
      stim_row arm;
      burst.delete();
      kind = $urandom_range(0, 99);
      start = $urandom_range(0, 1) ? START_A : START_B;
      arm = '{func_type'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), 1'b0, '0};
      if (kind < 15) begin
         burst.push_back(arm);
         return 1;
      end
      if (kind < 25) begin
         repeat ($urandom_range(1, 3)) burst.push_back(rx_row(8'($urandom_range(0, 255))));
         return 0;
      end
      burst.push_back(rx_row(start));
      if (kind < 35) begin
         // overrun: no tail before the buffer fills
         repeat (FRAME_LEN - 1) burst.push_back(rx_row(non_tail_byte()));
      end else if (kind < 45) begin
         repeat (FRAME_LEN - 2) burst.push_back(rx_row(non_tail_byte()));
         burst.push_back(rx_row(TAIL));
      end else begin
         shape = $urandom_range(0, 3);
         extra = $urandom_range(0, 2);
         case (shape)
            0: begin
               if ($urandom_range(0, 99) < 70)
                  burst.push_front('{(start == START_B) ? FUNC_ARM_SLIDE_CLEAR : FUNC_ARM_CAR,
                                     8'h00, 1'b0, '0});
               burst.push_back(rx_row(CMD_POS));
               burst.push_back(rx_row(ACK_REACHED));
            end
            1: begin
               burst.push_back(rx_row(CMD_CURRENT));
               // short current frames can leave a stale entry in byte 3
               repeat ($urandom_range(0, 2)) burst.push_back(rx_row(8'($urandom_range(0, 255))));
            end
            2: extra = $urandom_range(0, FRAME_LEN - 2);
            default: begin
               burst.push_back(rx_row(CMD_POS));
               burst.push_back(rx_row(8'($urandom_range(0, 255))));
            end
         endcase
         repeat (extra) burst.push_back(rx_row(8'($urandom_range(0, 255))));
         burst.push_back(rx_row(TAIL));
         if ($urandom_range(0, 99) < 20)
            burst.insert($urandom_range(1, burst.size() - 1), arm);
      end
      return burst.size();
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (idle_phase == 3 && hold_cycles < HOLD_LEN) begin
         // hold off long enough for the block to back up into its input
         hold_cycles++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      frame_reply want;
      frame_reply predicted;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (reply_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = reply_q.pop_front();
               if (rsp_car_status !== want.car)
                  report_mismatch($sformatf("car_status got %0d want %0d",
                                            rsp_car_status, want.car));
               if (rsp_slide_stopped !== want.slide)
                  report_mismatch($sformatf("slide_stopped got %0b want %0b",
                                            rsp_slide_stopped, want.slide));
               if (rsp_slide_current !== want.current)
                  report_mismatch($sformatf("slide_current got %h want %h",
                                            rsp_slide_current, want.current));
               if (rsp_frame_closed !== want.closed)
                  report_mismatch($sformatf("frame_closed got %0b want %0b",
                                            rsp_frame_closed, want.closed));
               if (rsp_frame_error !== want.error)
                  report_mismatch($sformatf("frame_error got %0b want %0b",
                                            rsp_frame_error, want.error));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            predicted = predict_reply(func_type'(req_func), req_rx_byte);
            reply_q.push_back(req_pinned ? pinned_reply : predicted);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      clear_frame(FRAME_LEN);
      directed_rows = '{
         '{FUNC_RX,              8'h00, 1'b1, '{CAR_STOPPED, 1'b1, 16'h0000, 1'b0, 1'b0}},
         '{FUNC_ARM_CAR,         8'h00, 1'b1, '{CAR_MOVING,  1'b1, 16'h0000, 1'b0, 1'b0}},
         // buffer fills with no tail
         '{FUNC_RX,              START_A, 1'b0, '0},
         '{FUNC_RX,              8'hFF, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              8'h80, 1'b0, '0},
         '{FUNC_RX,              8'h7F, 1'b0, '0},
         '{FUNC_RX,              8'h6A, 1'b0, '0},
         '{FUNC_RX,              8'h6C, 1'b0, '0},
         '{FUNC_RX,              START_A, 1'b0, '0},
         '{FUNC_RX,              START_B, 1'b0, '0},
         '{FUNC_RX,              8'hFE, 1'b1, '{CAR_ERROR,   1'b1, 16'h0000, 1'b1, 1'b1}},
         // current frame with the tail in the last slot
         '{FUNC_RX,              START_B, 1'b0, '0},
         '{FUNC_RX,              CMD_CURRENT, 1'b0, '0},
         '{FUNC_RX,              8'hFF, 1'b0, '0},
         '{FUNC_RX,              8'hFF, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              8'h00, 1'b0, '0},
         '{FUNC_RX,              TAIL,  1'b1, '{CAR_ERROR,   1'b1, 16'hFFFF, 1'b1, 1'b0}},
         // short current frame picks up a stale byte 3
         '{FUNC_RX,              START_B, 1'b0, '0},
         '{FUNC_RX,              CMD_CURRENT, 1'b0, '0},
         '{FUNC_RX,              TAIL,  1'b0, '0},
         // arm mid-frame, zeroed head then fails to match
         '{FUNC_RX,              START_B, 1'b0, '0},
         '{FUNC_ARM_SLIDE_CLEAR, 8'hFF, 1'b0, '0},
         '{FUNC_RX,              TAIL,  1'b0, '0},
         '{FUNC_ARM_CAR_CLEAR,   8'h00, 1'b0, '0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      for (int phase = 1; phase <= 3; phase++) begin
         send_idle_pct = (phase == 1) ? 28 : (phase == 2) ? 69 : 0;
         recv_idle_pct = (phase == 1) ? 69 : (phase == 2) ? 28 : 0;
         idle_phase = phase;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            sent += build_burst();
            foreach (burst[i]) send_request(burst[i]);
         end
      end
      req_valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
